>>> rtl/trigger_period_duty_meter_macros.svh
// Assertion helpers for the meter's top-level RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef TRIGGER_PERIOD_DUTY_METER_MACROS_SVH
`define TRIGGER_PERIOD_DUTY_METER_MACROS_SVH

// Same-cycle implication.
`define TPDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tpdm_pkg.sv
package tpdm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int DUTY_W    = 13;
    localparam int Q12_BITS  = 12;
    localparam int PC_W      = 2;
    localparam int MEDIAN_PERIODS = 3;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST    = 12'd1024;
    localparam logic                FALLING_EDGE_RST = 1'b0;
    localparam logic [DUTY_W-1:0]   DUTY_ONE         = 13'd4096;

    localparam logic [PC_W-1:0] PC_FULL  = PC_W'(MEDIAN_PERIODS);
    localparam logic [PC_W-1:0] LAST_IDX = PC_W'(MEDIAN_PERIODS - 1);

    // Register indexes of the configuration port
    localparam logic CFG_THRESHOLD    = 1'b0;
    localparam logic CFG_FALLING_EDGE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_START,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic            in_ready;
        logic            accept;
        logic            div_start;
        logic            duty_we;
        logic            finish;
        logic [PC_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [PC_W-1:0] period_count;
        logic            div_done;
        logic            out_free;
    } t_status;

endpackage

>>> rtl/tpdm_div.sv
module tpdm_div #(
    parameter int W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_num,
    input  logic [W-1:0]                i_den,
    output logic                        o_done,
    output logic [tpdm_pkg::DUTY_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(tpdm_pkg::DUTY_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(tpdm_pkg::DUTY_W);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic                        r_first, n_first;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [W:0]                  r_rem, n_rem;
    logic [W-1:0]                r_den, n_den;
    logic [tpdm_pkg::DUTY_W-1:0] r_quo, n_quo;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    // First step compares the numerator itself, later steps the doubled remainder
    always_comb begin
        trial = r_first ? r_rem : {r_rem[W-1:0], 1'b0};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_first = r_first;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy  = 1'b1;
            n_first = 1'b1;
            n_cnt   = STEPS;
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
            n_quo   = '0;
        end else if (r_busy) begin
            n_first = 1'b0;
            n_rem   = ge ? diff : trial;
            n_quo   = {r_quo[tpdm_pkg::DUTY_W-2:0], ge};
            n_cnt   = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    // Zero width reads as zero duty
    assign o_quo  = (r_den == '0) ? '0 : r_quo;

endmodule

>>> rtl/tpdm_ctrl.sv
module tpdm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_sample,
    input  tpdm_pkg::t_status i_status,
    output tpdm_pkg::t_cmd    o_cmd
);

    tpdm_pkg::t_state r_state, n_state;
    logic [tpdm_pkg::PC_W-1:0] r_k, n_k;
    logic more;

    assign more = (i_status.period_count == tpdm_pkg::PC_FULL) && (r_k != tpdm_pkg::LAST_IDX);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            tpdm_pkg::S_IDLE: begin
                if (i_in_valid && i_last_sample) n_state = tpdm_pkg::S_PREP;
            end
            tpdm_pkg::S_PREP: begin
                n_k     = '0;
                n_state = (i_status.period_count == '0) ? tpdm_pkg::S_FIN : tpdm_pkg::S_START;
            end
            tpdm_pkg::S_START: begin
                n_state = tpdm_pkg::S_DIV;
            end
            tpdm_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    if (more) begin
                        n_k     = r_k + tpdm_pkg::PC_W'(1);
                        n_state = tpdm_pkg::S_START;
                    end else begin
                        n_state = tpdm_pkg::S_FIN;
                    end
                end
            end
            tpdm_pkg::S_FIN: begin
                if (i_status.out_free) n_state = tpdm_pkg::S_IDLE;
            end
            default: n_state = tpdm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_k;
        o_cmd.in_ready  = (r_state == tpdm_pkg::S_IDLE);
        o_cmd.accept    = (r_state == tpdm_pkg::S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == tpdm_pkg::S_START);
        o_cmd.duty_we   = (r_state == tpdm_pkg::S_DIV) && i_status.div_done;
        o_cmd.finish    = (r_state == tpdm_pkg::S_FIN) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpdm_pkg::S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

endmodule

>>> rtl/tpdm_datapath.sv
module tpdm_datapath #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpdm_pkg::t_cmd                i_cmd,
    output tpdm_pkg::t_status             o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tpdm_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic [tpdm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [tpdm_pkg::SAMPLE_W-1:0] o_period_width,
    output logic [tpdm_pkg::DUTY_W-1:0]   o_duty_q12,
    output logic [tpdm_pkg::PC_W-1:0]     o_periods_seen,
    output logic [tpdm_pkg::SAMPLE_W-1:0] o_second_start
);

    localparam int SW    = tpdm_pkg::SAMPLE_W;
    localparam int DW    = tpdm_pkg::DUTY_W;
    localparam int PW    = tpdm_pkg::PC_W;
    localparam int NP    = tpdm_pkg::MEDIAN_PERIODS;
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int MED_W = (IDX_W > DW) ? IDX_W : DW;
    localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(MAX_SAMPLES - 1);

    function automatic logic [MED_W-1:0] med3(
        input logic [MED_W-1:0] a,
        input logic [MED_W-1:0] b,
        input logic [MED_W-1:0] c
    );
        logic [MED_W-1:0] lo;
        logic [MED_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    logic [SW-1:0]    r_threshold;
    logic             r_falling_edge;

    logic [SW-1:0]    r_prev_sample, n_prev_sample;
    logic             r_have_prev, n_have_prev;
    logic             r_armed, n_armed;
    logic [IDX_W-1:0] r_pair_index, n_pair_index;
    logic [IDX_W-1:0] r_start_index, n_start_index;
    logic [IDX_W-1:0] r_high_count, n_high_count;
    logic [PW-1:0]    r_period_count, n_period_count;
    logic             r_window_done, n_window_done;

    logic [IDX_W-1:0] r_width_store [NP];
    logic [IDX_W-1:0] r_count_store [NP];
    logic [DW-1:0]    r_duty_store  [NP];

    logic [SW-1:0]    r_held_width;
    logic [DW-1:0]    r_held_duty;
    logic [SW-1:0]    r_held_second, n_held_second;

    logic             r_out_valid;
    logic             r_out_found;
    logic [PW-1:0]    r_out_pc;
    logic [SW-1:0]    r_out_second;

    logic             hit;
    logic             at_or_above;
    logic             take;
    logic [IDX_W-1:0] hc_inc;
    logic             store_we;

    logic             div_done;
    logic [DW-1:0]    div_quo;

    logic [MED_W-1:0] med_width;
    logic [MED_W-1:0] med_duty;
    logic [MED_W-1:0] sec_ext;

    always_comb begin
        if (r_falling_edge) begin
            hit = (r_prev_sample >= r_threshold) && (i_sample < r_threshold);
        end else begin
            hit = (r_prev_sample <= r_threshold) && (i_sample > r_threshold);
        end
        at_or_above = (r_prev_sample >= r_threshold);
        hc_inc      = r_high_count + IDX_W'(at_or_above);
        take        = i_cmd.accept && r_have_prev && !r_window_done
                      && (r_pair_index < LAST_PAIR);
    end

    // Per-sample window tracking; finish clears it after the result is formed
    always_comb begin
        n_prev_sample  = r_prev_sample;
        n_have_prev    = r_have_prev;
        n_armed        = r_armed;
        n_pair_index   = r_pair_index;
        n_start_index  = r_start_index;
        n_high_count   = r_high_count;
        n_period_count = r_period_count;
        n_window_done  = r_window_done;
        n_held_second  = r_held_second;
        store_we       = 1'b0;

        if (i_cmd.accept) begin
            n_prev_sample = i_sample;
            n_have_prev   = 1'b1;
            if (r_have_prev && (r_pair_index < LAST_PAIR)) begin
                n_pair_index = r_pair_index + IDX_W'(1);
            end
        end

        sec_ext = MED_W'(r_pair_index);

        if (take) begin
            if (r_armed) begin
                n_high_count = hc_inc;
                if (hit) begin
                    store_we       = 1'b1;
                    n_period_count = r_period_count + PW'(1);
                    n_high_count   = '0;
                    if (r_period_count == tpdm_pkg::LAST_IDX) begin
                        n_window_done = 1'b1;
                        n_armed       = 1'b0;
                    end else begin
                        n_start_index = r_pair_index;
                        if (r_period_count == '0) n_held_second = sec_ext[SW-1:0];
                    end
                end
            end else if (hit) begin
                n_start_index = r_pair_index;
                n_armed       = 1'b1;
                if (r_period_count == PW'(1)) n_held_second = sec_ext[SW-1:0];
            end
        end

        if (i_cmd.finish) begin
            n_prev_sample  = '0;
            n_have_prev    = 1'b0;
            n_armed        = 1'b0;
            n_pair_index   = '0;
            n_start_index  = '0;
            n_high_count   = '0;
            n_period_count = '0;
            n_window_done  = 1'b0;
        end
    end

    always_comb begin
        med_width = med3(MED_W'(r_width_store[0]), MED_W'(r_width_store[1]),
                         MED_W'(r_width_store[2]));
        med_duty  = med3(MED_W'(r_duty_store[0]), MED_W'(r_duty_store[1]),
                         MED_W'(r_duty_store[2]));
        if (r_period_count != tpdm_pkg::PC_FULL) begin
            med_width = MED_W'(r_width_store[0]);
            med_duty  = MED_W'(r_duty_store[0]);
        end
    end

    tpdm_div #(
        .W (IDX_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_count_store[i_cmd.idx]),
        .i_den   (r_width_store[i_cmd.idx]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= tpdm_pkg::THRESHOLD_RST;
            r_falling_edge <= tpdm_pkg::FALLING_EDGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpdm_pkg::CFG_THRESHOLD:    r_threshold    <= i_cfg_data;
                tpdm_pkg::CFG_FALLING_EDGE: r_falling_edge <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample  <= '0;
            r_have_prev    <= 1'b0;
            r_armed        <= 1'b0;
            r_pair_index   <= '0;
            r_start_index  <= '0;
            r_high_count   <= '0;
            r_period_count <= '0;
            r_window_done  <= 1'b0;
            r_held_width   <= '0;
            r_held_duty    <= '0;
            r_held_second  <= '0;
            r_out_valid    <= 1'b0;
            r_out_found    <= 1'b0;
            r_out_pc       <= '0;
            r_out_second   <= '0;
        end else begin
            r_prev_sample  <= n_prev_sample;
            r_have_prev    <= n_have_prev;
            r_armed        <= n_armed;
            r_pair_index   <= n_pair_index;
            r_start_index  <= n_start_index;
            r_high_count   <= n_high_count;
            r_period_count <= n_period_count;
            r_window_done  <= n_window_done;
            r_held_second  <= n_held_second;
            if (i_cmd.finish) begin
                if (r_period_count != '0) begin
                    r_held_width <= med_width[SW-1:0];
                    r_held_duty  <= med_duty[DW-1:0];
                end
                r_out_valid  <= 1'b1;
                r_out_found  <= (r_period_count != '0);
                r_out_pc     <= r_period_count;
                r_out_second <= r_held_second;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Period stores hold no reset; only entries closed in this window are read
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_width_store[r_period_count] <= r_pair_index - r_start_index;
            r_count_store[r_period_count] <= hc_inc;
        end
        if (i_cmd.duty_we) begin
            r_duty_store[i_cmd.idx] <= div_quo;
        end
    end

    assign o_status.period_count = r_period_count;
    assign o_status.div_done     = div_done;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_period_width = r_held_width;
    assign o_duty_q12     = r_held_duty;
    assign o_periods_seen = r_out_pc;
    assign o_second_start = r_out_second;

endmodule

>>> rtl/trigger_period_duty_meter.sv
// Ordinary samples are accepted one per cycle while the meter is idle.
// The last sample of a window holds off input while duty is computed by one shared
// radix-2 divider, 13 steps per divided period; no period is divided when none was
// measured, only the first for one or two, each for three; the result is registered
// once the output is free; a waiting one does not stall sampling of the next window.
// Synchronous active-low reset: threshold 1024, rising edge, held values zero.
`include "trigger_period_duty_meter_macros.svh"

module trigger_period_duty_meter #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tpdm_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tpdm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [tpdm_pkg::SAMPLE_W-1:0] o_period_width,
    output logic [tpdm_pkg::DUTY_W-1:0]   o_duty_q12,
    output logic [tpdm_pkg::PC_W-1:0]     o_periods_seen,
    output logic [tpdm_pkg::SAMPLE_W-1:0] o_second_start
);

    tpdm_pkg::t_cmd    cmd;
    tpdm_pkg::t_status status;

    tpdm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    tpdm_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_period_width (o_period_width),
        .o_duty_q12     (o_duty_q12),
        .o_periods_seen (o_periods_seen),
        .o_second_start (o_second_start)
    );

    assign o_in_ready = cmd.in_ready;

    `TPDM_ASSERT_NXT(a_last_holds_input,
        i_in_valid && o_in_ready && i_last_sample, !o_in_ready,
        "input not held off after last beat")
    `TPDM_ASSERT_IMP(a_found_matches_count,
        o_out_valid, o_found == (o_periods_seen != 2'd0),
        "found disagrees with period count")
    `TPDM_ASSERT_IMP(a_duty_in_range,
        o_out_valid, o_duty_q12 <= tpdm_pkg::DUTY_ONE,
        "duty above full scale")

endmodule
